@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the parity encoder.
// No dependencies; simulation builds get checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rsenc_pkg.sv @@
// Package for the Reed-Solomon parity encoder: widths, field constants,
// cell control bundle and GF(2^8) arithmetic. No dependencies.
package rsenc_pkg;

    localparam int DATA_W       = 8;
    localparam int CFG_W        = 5;
    localparam int PARITY_RESET = 10;

    localparam logic [DATA_W-1:0] FIELD_REDUCE = 8'h1D;
    localparam logic [DATA_W-1:0] FIELD_ALPHA  = 8'h02;

    typedef logic [DATA_W-1:0] t_byte;

    // control shared by every cell of the chain
    typedef struct packed {
        logic init;        // load generator seed, clear remainder
        logic build;       // one generator root multiplication
        logic step;        // one data byte enters
        logic clear;       // last byte: remainder goes to zero
        logic drain_load;  // capture updated remainder for output
        logic drain_shift; // move output chain by one byte
    } t_cell_ctrl;

    // multiply two field elements, polynomial 0x11D
    function automatic t_byte gf_mul(input t_byte x, input t_byte y);
        t_byte acc;
        acc = '0;
        for (int b = DATA_W - 1; b >= 0; b--) begin
            acc = {acc[DATA_W-2:0], 1'b0} ^ (acc[DATA_W-1] ? FIELD_REDUCE : '0);
            acc = acc ^ (y[b] ? x : '0);
        end
        return acc;
    endfunction

    // multiply by the primitive element
    function automatic t_byte gf_xtime(input t_byte x);
        return {x[DATA_W-2:0], 1'b0} ^ (x[DATA_W-1] ? FIELD_REDUCE : '0);
    endfunction

endpackage

@@ rtl/rsenc_cell.sv @@
// One cell of the encoder chain: a remainder byte, a generator coefficient
// and an output drain byte, with one shared GF(2^8) multiplier. Uses rsenc_pkg.
module rsenc_cell (
    input  logic                 i_clk,
    input  rsenc_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_init_one,
    input  rsenc_pkg::t_byte     i_factor,
    input  rsenc_pkg::t_byte     i_root,
    input  rsenc_pkg::t_byte     i_rem_next,
    input  rsenc_pkg::t_byte     i_g_next,
    input  rsenc_pkg::t_byte     i_drain_next,
    output rsenc_pkg::t_byte     o_rem,
    output rsenc_pkg::t_byte     o_g,
    output rsenc_pkg::t_byte     o_drain
);
    import rsenc_pkg::*;

    t_byte r_rem;
    t_byte r_g;
    t_byte r_drain;
    t_byte w_prod;
    t_byte n_rem;

    // multiplier serves the generator build or the data step
    assign w_prod = gf_mul(r_g, i_ctrl.build ? i_root : i_factor);
    assign n_rem  = i_rem_next ^ w_prod;

    // generator coefficient and remainder
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_g   <= i_init_one ? t_byte'(1) : '0;
            r_rem <= '0;
        end else if (i_ctrl.build) begin
            r_g <= w_prod ^ i_g_next;
        end else if (i_ctrl.step) begin
            r_rem <= i_ctrl.clear ? '0 : n_rem;
        end
    end

    // output drain chain
    always_ff @(posedge i_clk) begin
        if (i_ctrl.drain_load) begin
            r_drain <= n_rem;
        end else if (i_ctrl.drain_shift) begin
            r_drain <= i_drain_next;
        end
    end

    assign o_rem   = r_rem;
    assign o_g     = r_g;
    assign o_drain = r_drain;

endmodule

@@ rtl/reed_solomon_parity_encoder_core.sv @@
// Top level of the systematic Reed-Solomon parity encoder over GF(2^8).
// Depends on rsenc_pkg, rsenc_cell and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one data byte per transfer,
//   i_last_in marking the final byte of a block. Output channel
//   (o_out_valid/i_out_ready) delivers the parity bytes, highest order
//   first, o_last_out on the final one. Config channel (i_cfg_valid/
//   o_cfg_ready) writes the parity count n; 0 reads as 1, larger than
//   MAX_PARITY saturates.
//   Throughput: one data byte per cycle outside a generator build. The first
//   parity byte is valid in the cycle after the last data byte transfers and
//   then n bytes drain at one per cycle while the receiver is ready, as the
//   next block's data keeps flowing. A last byte also waits if the previous
//   block's parity has not fully drained. After reset and after each config
//   write the generator is built one root per cycle across the cell chain,
//   with no data byte accepted meanwhile; n is 10 after reset. Reset clears
//   the remainder. A stalled receiver holds the current parity byte; the
//   chain shifts only on an output transfer.
module reed_solomon_parity_encoder_core #(
    parameter int MAX_PARITY = 30
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsenc_pkg::CFG_W-1:0]     i_cfg_parity_count,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rsenc_pkg::DATA_W-1:0]    i_data_byte,
    input  logic                            i_last_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rsenc_pkg::DATA_W-1:0]    o_parity_byte,
    output logic                            o_last_out
);
    import rsenc_pkg::*;

    `include "assert_macros.svh"

    localparam int NW      = $clog2(MAX_PARITY + 1);
    localparam int RESET_N = (PARITY_RESET > MAX_PARITY) ? MAX_PARITY : PARITY_RESET;

    logic [NW-1:0] r_n;
    logic [NW-1:0] r_build_cnt;
    logic [NW-1:0] r_out_cnt;
    t_byte         r_root;

    logic [NW-1:0] w_n_target;
    logic [31:0]   w_cfg_clamp;
    logic          w_cfg_xfer;
    logic          w_in_xfer;
    logic          w_out_xfer;
    logic          w_building;
    logic          w_drain_free;
    t_byte         w_factor;
    t_cell_ctrl    w_ctrl;

    t_byte w_rem   [0:MAX_PARITY];
    t_byte w_g     [0:MAX_PARITY];
    t_byte w_drain [0:MAX_PARITY];

    // handshakes
    assign o_cfg_ready  = 1'b1;
    assign w_cfg_xfer   = i_cfg_valid & o_cfg_ready;
    assign w_building   = (r_build_cnt != '0);
    assign w_out_xfer   = o_out_valid & i_out_ready;
    assign w_drain_free = (r_out_cnt == '0) || ((r_out_cnt == NW'(1)) && i_out_ready);
    assign o_in_ready   = !w_building && (!i_last_in || w_drain_free);
    assign w_in_xfer    = i_in_valid & o_in_ready;

    // saturate the written parity count into 1..MAX_PARITY
    always_comb begin
        w_cfg_clamp = {{(32 - CFG_W){1'b0}}, i_cfg_parity_count};
        if (w_cfg_clamp == 32'd0) begin
            w_cfg_clamp = 32'd1;
        end
        if (w_cfg_clamp > 32'(MAX_PARITY)) begin
            w_cfg_clamp = 32'(MAX_PARITY);
        end
    end

    assign w_n_target = !i_rst_n ? NW'(RESET_N) : w_cfg_clamp[NW-1:0];

    // cell control bundle
    always_comb begin
        w_ctrl.init        = !i_rst_n || w_cfg_xfer;
        w_ctrl.build       = w_building && !w_ctrl.init;
        w_ctrl.step        = w_in_xfer;
        w_ctrl.clear       = w_in_xfer && i_last_in;
        w_ctrl.drain_load  = w_in_xfer && i_last_in;
        w_ctrl.drain_shift = w_out_xfer;
    end

    // parity count, generator build sequencer, root register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= NW'(RESET_N);
            r_build_cnt <= NW'(RESET_N);
            r_root      <= t_byte'(1);
        end else if (w_cfg_xfer) begin
            r_n         <= w_n_target;
            r_build_cnt <= w_n_target;
            r_root      <= t_byte'(1);
        end else if (w_building) begin
            r_build_cnt <= r_build_cnt - NW'(1);
            r_root      <= gf_xtime(r_root);
        end
    end

    // parity bytes left to deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= '0;
        end else if (w_ctrl.drain_load) begin
            r_out_cnt <= r_n;
        end else if (w_out_xfer) begin
            r_out_cnt <= r_out_cnt - NW'(1);
        end
    end

    // feedback term broadcast to all cells
    assign w_factor = i_data_byte ^ w_rem[0];

    // chain end feeds zeros
    assign w_rem[MAX_PARITY]   = '0;
    assign w_g[MAX_PARITY]     = '0;
    assign w_drain[MAX_PARITY] = '0;

    // row of cells, cell j holds remainder byte j
    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        rsenc_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_init_one   (w_n_target == NW'(j + 1)),
            .i_factor     (w_factor),
            .i_root       (r_root),
            .i_rem_next   (w_rem[j+1]),
            .i_g_next     (w_g[j+1]),
            .i_drain_next (w_drain[j+1]),
            .o_rem        (w_rem[j]),
            .o_g          (w_g[j]),
            .o_drain      (w_drain[j])
        );
    end

    // output register is the head of the drain chain
    assign o_out_valid   = (r_out_cnt != '0);
    assign o_parity_byte = w_drain[0];
    assign o_last_out    = (r_out_cnt == NW'(1));

    // checks
    `ASSERT_NEXT(a_last_gives_output, i_clk, i_rst_n, w_in_xfer && i_last_in, o_out_valid)
    `ASSERT_NEXT(a_cfg_starts_build, i_clk, i_rst_n, w_cfg_xfer, w_building && !o_in_ready)
    `ASSERT_HOLDS(a_count_range, i_clk, i_rst_n, (r_n != '0) && (r_n <= NW'(MAX_PARITY)))
    `ASSERT_HOLDS(a_drain_bounded, i_clk, i_rst_n, r_out_cnt <= r_n)

endmodule
